### design/nlg_pkg.sv
`timescale 1ns / 1ps
package nlg_pkg;

  localparam int AXES = 3;

  typedef logic [5:0] idx_t;
  typedef logic [1:0] ax_t;
  typedef logic [AXES-1:0][31:0] vec_t;

  localparam ax_t AX_LAST = ax_t'(AXES - 1);

  localparam logic [1:0] REG_BODY_COUNT = 2'd0;
  localparam logic [1:0] REG_TIME_STEP  = 2'd1;
  localparam logic [1:0] REG_STEP_COUNT = 2'd2;

  localparam logic [63:0] QUOT_CAP = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [31:0] body_mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic last_body;
  } in_item_t;

  typedef struct packed {
    logic [5:0] body_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic last_result;
  } out_item_t;

  typedef struct packed {
    logic [31:0] mass;
    vec_t pos;
    vec_t vel;
    vec_t acc;
  } body_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_LOAD,
    CELL_ACC
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    idx_t sel;
    idx_t tail;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD_MA,
    ST_UPD_AV,
    ST_UPD_MV,
    ST_UPD_ROT,
    ST_PAIR_INIT,
    ST_PAIR_START,
    ST_PAIR_WAIT,
    ST_PAIR_NEXT,
    ST_PAIR_WB,
    ST_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_SQ,
    F_SUM,
    F_CHK,
    F_SQRT,
    F_DIV1,
    F_DIV2,
    F_DIVU,
    F_MLO,
    F_MHI,
    F_TSUM,
    F_ACC,
    F_FIN
  } force_state_t;

  function automatic logic [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) return 32'h7fff_ffff;
    if (x < -50'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] d);
    return d[31] ? (~d + 32'd1) : d;
  endfunction

  function automatic logic [47:0] cap48(input logic [63:0] q);
    return (q > QUOT_CAP) ? QUOT_CAP[47:0] : q[47:0];
  endfunction

endpackage

### design/nlg_cell.sv
`timescale 1ns / 1ps
module nlg_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  nlg_pkg::cell_ctrl_t ctrl_i,
  input  nlg_pkg::body_t      nbr_i,
  input  nlg_pkg::body_t      feed_i,
  output nlg_pkg::body_t      body_o
);

  localparam nlg_pkg::idx_t MyIdx = nlg_pkg::idx_t'(CELL_IDX);

  nlg_pkg::body_t body_r;
  nlg_pkg::body_t body_nxt;

  always_comb begin
    body_nxt = body_r;
    case (ctrl_i.op)
      nlg_pkg::CELL_ROT: begin
        // the tail cell closes the ring; cells past it keep stale bodies
        if (MyIdx < ctrl_i.tail) body_nxt = nbr_i;
        else if (MyIdx == ctrl_i.tail) body_nxt = feed_i;
      end
      nlg_pkg::CELL_LOAD: begin
        if (MyIdx == ctrl_i.sel) body_nxt = feed_i;
      end
      nlg_pkg::CELL_ACC: begin
        if (MyIdx == ctrl_i.sel) body_nxt.acc = feed_i.acc;
      end
      default: body_nxt = body_r;
    endcase
  end

  always_ff @(posedge clk) begin
    body_r <= body_nxt;
  end

  assign body_o = body_r;

endmodule

### design/nlg_div.sv
`timescale 1ns / 1ps
module nlg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [32:0] tmp;
  logic        ge;

  assign tmp = {rem_r, quo_r[63]};
  assign ge  = tmp >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (busy_r) begin
      rem_r <= ge ? 32'(tmp - {1'b0, dvs_r}) : tmp[31:0];
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

### design/nlg_sqrt.sv
`timescale 1ns / 1ps
module nlg_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] sum;

  assign sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // two radicand bits per cycle; leading zero steps leave res at zero
  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r   <= x_i;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (x_r >= sum) begin
        x_r   <= x_r - sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done_o = done_r;
  assign root_o = res_r[31:0];

endmodule

### design/nlg_force.sv
`timescale 1ns / 1ps
module nlg_force (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_i,
  input  logic           sub_i,
  input  nlg_pkg::vec_t  piv_pos_i,
  input  nlg_pkg::body_t part_i,
  input  nlg_pkg::vec_t  acc_i,
  output logic           done_o,
  output nlg_pkg::vec_t  acc_o
);

  nlg_pkg::force_state_t state_r, state_nxt;

  logic signed [31:0] d_r [nlg_pkg::AXES];
  logic [63:0]        sq_r [nlg_pkg::AXES];
  logic [16:0]        u_r [nlg_pkg::AXES];
  logic [63:0]        r2_r;
  logic [47:0]        g_r;
  logic [31:0]        mass_r;
  logic [40:0]        plo_r;
  logic [40:0]        phi_r;
  logic [47:0]        t_r;
  logic               sub_r;
  nlg_pkg::ax_t       ax_r;
  nlg_pkg::vec_t      acc_r;

  logic        sq_start, sq_done;
  logic [31:0] root;
  logic        dv_start, dv_done;
  logic [63:0] dv_dividend, dv_quo;
  logic [64:0] tsum;
  logic        neg;
  logic signed [49:0] contrib;

  nlg_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sq_start),
    .x_i     (r2_r),
    .done_o  (sq_done),
    .root_o  (root)
  );

  nlg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (root),
    .done_o     (dv_done),
    .quo_o      (dv_quo)
  );

  always_comb begin
    state_nxt   = state_r;
    sq_start    = 1'b0;
    dv_start    = 1'b0;
    dv_dividend = '0;
    case (state_r)
      nlg_pkg::F_IDLE: if (start_i) state_nxt = nlg_pkg::F_SQ;
      nlg_pkg::F_SQ:   state_nxt = nlg_pkg::F_SUM;
      nlg_pkg::F_SUM:  state_nxt = nlg_pkg::F_CHK;
      nlg_pkg::F_CHK: begin
        // coincident bodies exert no pull
        if (r2_r == '0) begin
          state_nxt = nlg_pkg::F_FIN;
        end else begin
          sq_start  = 1'b1;
          state_nxt = nlg_pkg::F_SQRT;
        end
      end
      nlg_pkg::F_SQRT: begin
        dv_dividend = {16'd0, mass_r, 16'd0};
        if (sq_done) begin
          dv_start  = 1'b1;
          state_nxt = nlg_pkg::F_DIV1;
        end
      end
      nlg_pkg::F_DIV1: begin
        dv_dividend = {nlg_pkg::cap48(dv_quo), 16'd0};
        if (dv_done) begin
          dv_start  = 1'b1;
          state_nxt = nlg_pkg::F_DIV2;
        end
      end
      nlg_pkg::F_DIV2: begin
        dv_dividend = {16'd0, nlg_pkg::mag32(d_r[0]), 16'd0};
        if (dv_done) begin
          dv_start  = 1'b1;
          state_nxt = nlg_pkg::F_DIVU;
        end
      end
      nlg_pkg::F_DIVU: begin
        if (ax_r != nlg_pkg::AX_LAST) begin
          dv_dividend = {16'd0, nlg_pkg::mag32(d_r[ax_r + 2'd1]), 16'd0};
        end
        if (dv_done) begin
          if (ax_r == nlg_pkg::AX_LAST) begin
            state_nxt = nlg_pkg::F_MLO;
          end else begin
            dv_start = 1'b1;
          end
        end
      end
      nlg_pkg::F_MLO:  state_nxt = nlg_pkg::F_MHI;
      nlg_pkg::F_MHI:  state_nxt = nlg_pkg::F_TSUM;
      nlg_pkg::F_TSUM: state_nxt = nlg_pkg::F_ACC;
      nlg_pkg::F_ACC: begin
        state_nxt = (ax_r == nlg_pkg::AX_LAST) ? nlg_pkg::F_FIN : nlg_pkg::F_MLO;
      end
      nlg_pkg::F_FIN:  state_nxt = nlg_pkg::F_IDLE;
      default:         state_nxt = nlg_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= nlg_pkg::F_IDLE;
    else state_r <= state_nxt;
  end

  assign tsum    = {phi_r, 24'd0} + {24'd0, plo_r};
  assign neg     = d_r[ax_r][31] ^ sub_r;
  assign contrib = neg ? -$signed({2'b00, t_r}) : $signed({2'b00, t_r});

  always_ff @(posedge clk) begin
    case (state_r)
      nlg_pkg::F_IDLE: begin
        if (start_i) begin
          for (int k = 0; k < nlg_pkg::AXES; k++) begin
            d_r[k] <= sub_i
              ? nlg_pkg::sat32(50'($signed(piv_pos_i[k])) - 50'($signed(part_i.pos[k])))
              : nlg_pkg::sat32(50'($signed(part_i.pos[k])) - 50'($signed(piv_pos_i[k])));
          end
          mass_r <= part_i.mass;
          acc_r  <= acc_i;
          sub_r  <= sub_i;
        end
      end
      nlg_pkg::F_SQ: begin
        for (int k = 0; k < nlg_pkg::AXES; k++) sq_r[k] <= $signed(d_r[k]) * $signed(d_r[k]);
      end
      nlg_pkg::F_SUM: r2_r <= sq_r[0] + sq_r[1] + sq_r[2];
      nlg_pkg::F_DIV2: begin
        if (dv_done) begin
          g_r  <= nlg_pkg::cap48(dv_quo);
          ax_r <= '0;
        end
      end
      nlg_pkg::F_DIVU: begin
        if (dv_done) begin
          u_r[ax_r] <= dv_quo[16:0];
          ax_r      <= (ax_r == nlg_pkg::AX_LAST) ? '0 : ax_r + 2'd1;
        end
      end
      nlg_pkg::F_MLO:  plo_r <= g_r[23:0] * u_r[ax_r];
      nlg_pkg::F_MHI:  phi_r <= g_r[47:24] * u_r[ax_r];
      nlg_pkg::F_TSUM: t_r   <= tsum[63:16];
      nlg_pkg::F_ACC: begin
        acc_r[ax_r] <= nlg_pkg::sat32(50'($signed(acc_r[ax_r])) + contrib);
        ax_r        <= ax_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign done_o = (state_r == nlg_pkg::F_FIN);
  assign acc_o  = acc_r;

endmodule

### design/nbody_leapfrog_gravity.sv
`timescale 1ns / 1ps
// Direct-sum gravity N-body integrator (G = 1, signed Q16.16, saturating).
// Bodies load one per transfer; the transfer flagged
// last_body starts step_count kick-drift-kick steps over n = min(body_count,
// MAX_BODIES) bodies, then n results stream out in index order, one per cycle
// while out_ready is high. Bodies live in a ring of cells that rotates past a
// single shared force engine, and each ordered pair is evaluated from the
// side of the body being accelerated. A pair takes one 32-step square root
// and five 64-step divisions on the shared serial divider.
// Input is taken again once the run is over.
module nbody_leapfrog_gravity #(
  parameter int MAX_BODIES = 64,
  parameter int DIMENSIONS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nlg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nlg_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic [6:0] MaxN = 7'(MAX_BODIES);

  nlg_pkg::top_state_t state_r, state_nxt;

  logic [6:0]    body_count_r;
  logic [15:0]   time_step_r;
  logic [15:0]   step_count_r;
  logic [6:0]    load_cnt_r, load_cnt_nxt;
  nlg_pkg::idx_t cnt_r, cnt_nxt;
  nlg_pkg::idx_t k_r, k_nxt;
  nlg_pkg::idx_t b_r, b_nxt;
  logic [15:0]   step_r, step_nxt;
  logic          drift_r, drift_nxt;

  logic               out_valid_r;
  nlg_pkg::out_item_t out_data_r;
  logic               out_load;

  logic signed [48:0] prod_a_r [nlg_pkg::AXES];
  logic signed [48:0] prod_v_r [nlg_pkg::AXES];
  logic signed [31:0] vnew_r [nlg_pkg::AXES];
  nlg_pkg::vec_t      piv_pos_r;
  nlg_pkg::vec_t      npiv_pos_r;
  nlg_pkg::vec_t      piv_acc_r;

  logic [6:0]          n;
  nlg_pkg::idx_t       n_last;
  nlg_pkg::cell_ctrl_t cell_ctrl;
  nlg_pkg::body_t      feed;
  nlg_pkg::body_t      head;
  nlg_pkg::body_t      bodies [MAX_BODIES];
  nlg_pkg::vec_t       in_pos, in_vel;

  logic          fs_start, fs_done;
  nlg_pkg::vec_t fs_acc;

  assign n      = (body_count_r > MaxN) ? MaxN : body_count_r;
  assign n_last = nlg_pkg::idx_t'(n - 7'd1);
  assign head   = bodies[0];

  assign in_pos = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign in_vel = {in_data.vel_z, in_data.vel_y, in_data.vel_x};

  generate
    for (genvar c = 0; c < MAX_BODIES; c++) begin : g_cell
      if (c == MAX_BODIES - 1) begin : g_end
        nlg_cell #(.CELL_IDX(c)) u_cell (
          .clk    (clk),
          .ctrl_i (cell_ctrl),
          .nbr_i  (feed),
          .feed_i (feed),
          .body_o (bodies[c])
        );
      end else begin : g_mid
        nlg_cell #(.CELL_IDX(c)) u_cell (
          .clk    (clk),
          .ctrl_i (cell_ctrl),
          .nbr_i  (bodies[c+1]),
          .feed_i (feed),
          .body_o (bodies[c])
        );
      end
    end
  endgenerate

  nlg_force u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (fs_start),
    .sub_i     (k_r < b_r),
    .piv_pos_i (piv_pos_r),
    .part_i    (head),
    .acc_i     (piv_acc_r),
    .done_o    (fs_done),
    .acc_o     (fs_acc)
  );

  always_comb begin
    state_nxt      = state_r;
    load_cnt_nxt   = load_cnt_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    b_nxt          = b_r;
    step_nxt       = step_r;
    drift_nxt      = drift_r;
    cell_ctrl.op   = nlg_pkg::CELL_HOLD;
    cell_ctrl.sel  = load_cnt_r[5:0];
    cell_ctrl.tail = n_last;
    feed           = head;
    fs_start       = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      nlg_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (load_cnt_r < n) begin
            cell_ctrl.op = nlg_pkg::CELL_LOAD;
            feed.mass    = in_data.body_mass;
            for (int k = 0; k < nlg_pkg::AXES; k++) begin
              feed.pos[k] = (k < DIMENSIONS) ? in_pos[k] : '0;
              feed.vel[k] = (k < DIMENSIONS) ? in_vel[k] : '0;
              feed.acc[k] = '0;
            end
            load_cnt_nxt = load_cnt_r + 7'd1;
          end
          if (in_data.last_body) begin
            load_cnt_nxt = '0;
            cnt_nxt      = '0;
            step_nxt     = '0;
            if (n != 7'd0) begin
              if (step_count_r == 16'd0) begin
                state_nxt = nlg_pkg::ST_OUT;
              end else begin
                drift_nxt = 1'b1;
                state_nxt = nlg_pkg::ST_UPD_MA;
              end
            end
          end
        end
      end
      nlg_pkg::ST_UPD_MA: state_nxt = nlg_pkg::ST_UPD_AV;
      nlg_pkg::ST_UPD_AV: state_nxt = drift_r ? nlg_pkg::ST_UPD_MV : nlg_pkg::ST_UPD_ROT;
      nlg_pkg::ST_UPD_MV: state_nxt = nlg_pkg::ST_UPD_ROT;
      nlg_pkg::ST_UPD_ROT: begin
        cell_ctrl.op = nlg_pkg::CELL_ROT;
        for (int k = 0; k < nlg_pkg::AXES; k++) begin
          feed.pos[k] = drift_r
            ? nlg_pkg::sat32(50'($signed(head.pos[k])) + 50'(prod_v_r[k] >>> 16))
            : head.pos[k];
          feed.vel[k] = vnew_r[k];
          feed.acc[k] = drift_r ? '0 : head.acc[k];
        end
        if (cnt_r == n_last) begin
          cnt_nxt = '0;
          if (drift_r) begin
            state_nxt = nlg_pkg::ST_PAIR_INIT;
          end else if ({1'b0, step_r} + 17'd1 == {1'b0, step_count_r}) begin
            state_nxt = nlg_pkg::ST_OUT;
          end else begin
            step_nxt  = step_r + 16'd1;
            drift_nxt = 1'b1;
            state_nxt = nlg_pkg::ST_UPD_MA;
          end
        end else begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = nlg_pkg::ST_UPD_MA;
        end
      end
      nlg_pkg::ST_PAIR_INIT: begin
        k_nxt     = '0;
        b_nxt     = '0;
        state_nxt = nlg_pkg::ST_PAIR_START;
      end
      nlg_pkg::ST_PAIR_START: begin
        if (k_r == b_r) begin
          state_nxt = nlg_pkg::ST_PAIR_NEXT;
        end else begin
          fs_start  = 1'b1;
          state_nxt = nlg_pkg::ST_PAIR_WAIT;
        end
      end
      nlg_pkg::ST_PAIR_WAIT: if (fs_done) state_nxt = nlg_pkg::ST_PAIR_NEXT;
      nlg_pkg::ST_PAIR_NEXT: begin
        cell_ctrl.op = nlg_pkg::CELL_ROT;
        if (k_r == n_last) begin
          state_nxt = nlg_pkg::ST_PAIR_WB;
        end else begin
          k_nxt     = k_r + 6'd1;
          state_nxt = nlg_pkg::ST_PAIR_START;
        end
      end
      nlg_pkg::ST_PAIR_WB: begin
        // ring is back home here, so the pivot's cell is its own index
        cell_ctrl.op  = nlg_pkg::CELL_ACC;
        cell_ctrl.sel = b_r;
        feed.acc      = piv_acc_r;
        if (b_r == n_last) begin
          drift_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = nlg_pkg::ST_UPD_MA;
        end else begin
          b_nxt     = b_r + 6'd1;
          k_nxt     = '0;
          state_nxt = nlg_pkg::ST_PAIR_START;
        end
      end
      nlg_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load     = 1'b1;
          cell_ctrl.op = nlg_pkg::CELL_ROT;
          if (cnt_r == n_last) begin
            state_nxt = nlg_pkg::ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
      end
      default: state_nxt = nlg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nlg_pkg::ST_IDLE;
      load_cnt_r   <= '0;
      cnt_r        <= '0;
      k_r          <= '0;
      b_r          <= '0;
      step_r       <= '0;
      drift_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      body_count_r <= 7'd2;
      time_step_r  <= 16'd66;
      step_count_r <= 16'd1000;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      cnt_r      <= cnt_nxt;
      k_r        <= k_nxt;
      b_r        <= b_nxt;
      step_r     <= step_nxt;
      drift_r    <= drift_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          nlg_pkg::REG_BODY_COUNT: body_count_r <= cfg_data[6:0];
          nlg_pkg::REG_TIME_STEP:  time_step_r  <= cfg_data;
          nlg_pkg::REG_STEP_COUNT: step_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      nlg_pkg::ST_UPD_MA: begin
        for (int k = 0; k < nlg_pkg::AXES; k++)
          prod_a_r[k] <= $signed(head.acc[k]) * $signed({1'b0, time_step_r});
      end
      nlg_pkg::ST_UPD_AV: begin
        for (int k = 0; k < nlg_pkg::AXES; k++)
          vnew_r[k] <= nlg_pkg::sat32(50'($signed(head.vel[k])) + 50'(prod_a_r[k] >>> 17));
      end
      nlg_pkg::ST_UPD_MV: begin
        for (int k = 0; k < nlg_pkg::AXES; k++)
          prod_v_r[k] <= $signed(vnew_r[k]) * $signed({1'b0, time_step_r});
      end
      nlg_pkg::ST_PAIR_INIT: begin
        piv_pos_r <= head.pos;
        piv_acc_r <= '0;
      end
      nlg_pkg::ST_PAIR_START: begin
        // grab the next pivot as it passes the head
        if (k_r == nlg_pkg::idx_t'(b_r + 6'd1)) npiv_pos_r <= head.pos;
      end
      nlg_pkg::ST_PAIR_WAIT: if (fs_done) piv_acc_r <= fs_acc;
      nlg_pkg::ST_PAIR_WB: begin
        piv_pos_r <= npiv_pos_r;
        piv_acc_r <= '0;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r.body_index  <= cnt_r;
      out_data_r.out_pos_x   <= head.pos[0];
      out_data_r.out_pos_y   <= head.pos[1];
      out_data_r.out_pos_z   <= head.pos[2];
      out_data_r.out_vel_x   <= head.vel[0];
      out_data_r.out_vel_y   <= head.vel[1];
      out_data_r.out_vel_z   <= head.vel[2];
      out_data_r.last_result <= (cnt_r == n_last);
    end
  end

  assign in_ready  = (state_r == nlg_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_wb_after_full_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nlg_pkg::ST_PAIR_WB) |-> (k_r == n_last))
    else $error("acc writeback before the ring returned home");

  a_pass_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nlg_pkg::ST_UPD_ROT || state_r == nlg_pkg::ST_OUT) |-> (cnt_r <= n_last))
    else $error("pass counter ran past the last body");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_result) |-> (out_data_r.body_index == n_last))
    else $error("last result flag on the wrong body");

  a_force_done: assert property (@(posedge clk) disable iff (!rst_n)
    fs_done |-> (state_r == nlg_pkg::ST_PAIR_WAIT))
    else $error("force engine finished while nothing waited on it");
`endif

endmodule
